// ----- rtl/dwsv_pkg.sv -----
package dwsv_pkg;

  localparam int RING_DEPTH  = 1024;
  localparam int PTR_W       = $clog2(RING_DEPTH);
  localparam int FILL_W      = $clog2(RING_DEPTH + 1);
  localparam int YEAR_W      = 16;
  localparam int COUNT_W     = 11;
  localparam int COUNT_MAX   = (1 << COUNT_W) - 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] best_count;
    logic [YEAR_W-1:0]  best_start;
    logic [YEAR_W-1:0]  best_end;
    logic               overflow;
  } out_item_t;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(RING_DEPTH - 1)) begin
      next_ptr = '0;
    end else begin
      next_ptr = p + 1'b1;
    end
  endfunction

  function automatic logic [COUNT_W-1:0] sat_count(input logic [FILL_W-1:0] c);
    logic [31:0] cw;
    cw = 32'(c);
    if (cw > 32'(COUNT_MAX)) begin
      sat_count = COUNT_W'(COUNT_MAX);
    end else begin
      sat_count = cw[COUNT_W-1:0];
    end
  endfunction

endpackage

// ----- rtl/densest_window_of_sorted_values.sv -----
// Channel   Ports                                  Moves
// input     in_valid, in_ready, in_data            one sorted value and its last flag
// result    out_valid, out_ready, out_data         count, start, end and overflow of a set
// config    cfg_we, cfg_wdata                      window span, written without wait
//
// An item passes from the idle state through one compare step for each value it evicts, plus one more
// compare step when a value stays in the window, to the push step; a full ring adds a top step. The single
// read port of the ring memory sets this.
// Reset needs no clearing pass, since only written ring entries are read.
// A two-item queue keeps accepting input, until it is full, while the back part works or a result waits.
// A result that is not taken stalls the back part only on the last item of the next set.
module densest_window_of_sorted_values (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  dwsv_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output dwsv_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [dwsv_pkg::YEAR_W-1:0] cfg_wdata
);

  logic [dwsv_pkg::YEAR_W-1:0] window_r;
  logic [dwsv_pkg::YEAR_W-1:0] span;
  logic                        q_valid;
  logic                        q_ready;
  dwsv_pkg::in_item_t          q_item;

  // A span of zero behaves as a span of one.
  assign span = (window_r == '0) ? dwsv_pkg::YEAR_W'(1) : window_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= dwsv_pkg::YEAR_W'(1);
    end else if (cfg_we) begin
      window_r <= cfg_wdata;
    end
  end

  dwsv_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  dwsv_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .span     (span),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ----- rtl/dwsv_ram.sv -----
module dwsv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// ----- rtl/dwsv_front.sv -----
module dwsv_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dwsv_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_ready,
  output dwsv_pkg::in_item_t q_item
);

  dwsv_pkg::in_item_t               slot_r [dwsv_pkg::QUEUE_DEPTH];
  logic [dwsv_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [dwsv_pkg::QPTR_W-1:0]      wr_ptr_nxt;
  logic [dwsv_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [dwsv_pkg::QPTR_W-1:0]      rd_ptr_nxt;
  logic [dwsv_pkg::QCNT_W-1:0]      cnt_r;
  logic [dwsv_pkg::QCNT_W-1:0]      cnt_nxt;
  logic                             push;
  logic                             pop;

  assign in_ready = (cnt_r != dwsv_pkg::QCNT_W'(dwsv_pkg::QUEUE_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = slot_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      if (wr_ptr_r == dwsv_pkg::QPTR_W'(dwsv_pkg::QUEUE_DEPTH - 1)) begin
        wr_ptr_nxt = '0;
      end else begin
        wr_ptr_nxt = wr_ptr_r + 1'b1;
      end
    end
    if (pop) begin
      if (rd_ptr_r == dwsv_pkg::QPTR_W'(dwsv_pkg::QUEUE_DEPTH - 1)) begin
        rd_ptr_nxt = '0;
      end else begin
        rd_ptr_nxt = rd_ptr_r + 1'b1;
      end
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

// ----- rtl/dwsv_back.sv -----
module dwsv_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [dwsv_pkg::YEAR_W-1:0]  span,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  dwsv_pkg::in_item_t           q_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output dwsv_pkg::out_item_t          out_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CMP  = 3'd1;
  localparam logic [2:0] ST_PUSH = 3'd2;
  localparam logic [2:0] ST_TOP  = 3'd3;
  localparam logic [2:0] ST_HOLD = 3'd4;

  localparam int YW = dwsv_pkg::YEAR_W;
  localparam int PW = dwsv_pkg::PTR_W;
  localparam int FW = dwsv_pkg::FILL_W;

  logic [2:0]        state_r, state_nxt;
  logic [PW-1:0]     head_r, head_nxt;
  logic [PW-1:0]     tail_r, tail_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic [FW-1:0]     top_cnt_r, top_cnt_nxt;
  logic [YW-1:0]     top_start_r, top_start_nxt;
  logic [YW-1:0]     top_end_r, top_end_nxt;
  logic              ovf_r, ovf_nxt;
  logic              out_valid_r, out_valid_nxt;
  dwsv_pkg::out_item_t out_item_r, out_item_nxt;
  logic [YW-1:0]     val_r, val_nxt;
  logic              last_r, last_nxt;
  logic [YW-1:0]     front_r, front_nxt;

  logic              rd_en;
  logic [PW-1:0]     rd_addr;
  logic [YW-1:0]     rd_data;
  logic              wr_en;
  logic              fin;
  logic [FW-1:0]     cand_cnt;
  logic [YW-1:0]     cand_start;
  logic              emit_ok;
  logic              evict;
  logic              full;

  dwsv_ram #(
    .WIDTH(YW),
    .DEPTH(dwsv_pkg::RING_DEPTH)
  ) u_ring (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(tail_r),
    .wr_data(val_r),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign q_ready   = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;
  assign emit_ok   = !out_valid_r || out_ready;
  assign evict     = (({1'b0, rd_data} + {1'b0, span}) <= {1'b0, val_r});
  assign full      = (fill_r == FW'(dwsv_pkg::RING_DEPTH));

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    top_cnt_nxt   = top_cnt_r;
    top_start_nxt = top_start_r;
    top_end_nxt   = top_end_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    front_nxt     = front_r;
    rd_en         = 1'b0;
    rd_addr       = head_r;
    wr_en         = 1'b0;
    fin           = 1'b0;
    cand_cnt      = fill_r;
    cand_start    = rd_data;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          val_nxt  = q_item.year;
          last_nxt = q_item.last;
          if (fill_r != '0) begin
            rd_en     = 1'b1;
            state_nxt = ST_CMP;
          end else begin
            state_nxt = ST_PUSH;
          end
        end
      end
      ST_CMP: begin
        if (evict) begin
          head_nxt = dwsv_pkg::next_ptr(head_r);
          fill_nxt = fill_r - 1'b1;
          if (fill_r > FW'(1)) begin
            rd_en   = 1'b1;
            rd_addr = dwsv_pkg::next_ptr(head_r);
          end else begin
            state_nxt = ST_PUSH;
          end
        end else begin
          front_nxt = rd_data;
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        wr_en    = 1'b1;
        tail_nxt = dwsv_pkg::next_ptr(tail_r);
        if (full) begin
          head_nxt  = dwsv_pkg::next_ptr(head_r);
          ovf_nxt   = 1'b1;
          rd_en     = 1'b1;
          rd_addr   = dwsv_pkg::next_ptr(head_r);
          state_nxt = ST_TOP;
        end else begin
          fill_nxt   = fill_r + 1'b1;
          cand_cnt   = fill_r + 1'b1;
          cand_start = (fill_r == '0) ? val_r : front_r;
          fin        = 1'b1;
        end
      end
      ST_TOP: begin
        cand_cnt   = fill_r;
        cand_start = rd_data;
        fin        = 1'b1;
      end
      ST_HOLD: begin
        if (emit_ok) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.best_count = dwsv_pkg::sat_count(top_cnt_r);
          out_item_nxt.best_start = top_start_r;
          out_item_nxt.best_end   = top_end_r;
          out_item_nxt.overflow   = ovf_r;
          head_nxt                = '0;
          tail_nxt                = '0;
          fill_nxt                = '0;
          top_cnt_nxt             = '0;
          top_start_nxt           = '0;
          top_end_nxt             = '0;
          ovf_nxt                 = 1'b0;
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (fin) begin
      if (cand_cnt > top_cnt_r) begin
        top_cnt_nxt   = cand_cnt;
        top_start_nxt = cand_start;
        top_end_nxt   = val_r;
      end
      if (!last_r) begin
        state_nxt = ST_IDLE;
      end else if (emit_ok) begin
        out_valid_nxt           = 1'b1;
        out_item_nxt.best_count = dwsv_pkg::sat_count(top_cnt_nxt);
        out_item_nxt.best_start = top_start_nxt;
        out_item_nxt.best_end   = top_end_nxt;
        out_item_nxt.overflow   = ovf_nxt;
        head_nxt                = '0;
        tail_nxt                = '0;
        fill_nxt                = '0;
        top_cnt_nxt             = '0;
        top_start_nxt           = '0;
        top_end_nxt             = '0;
        ovf_nxt                 = 1'b0;
        state_nxt               = ST_IDLE;
      end else begin
        state_nxt = ST_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      top_cnt_r   <= '0;
      top_start_r <= '0;
      top_end_r   <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      top_cnt_r   <= top_cnt_nxt;
      top_start_r <= top_start_nxt;
      top_end_r   <= top_end_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    val_r      <= val_nxt;
    last_r     <= last_nxt;
    front_r    <= front_nxt;
  end

endmodule

// ----- tb/sv/densest_window_tracker.sv -----
`timescale 1ns / 100ps
module densest_window_tracker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  dwsv_pkg::in_item_t          in_data,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  dwsv_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [dwsv_pkg::YEAR_W-1:0] cfg_wdata,
  output int                          mismatches,
  output int                          sets_pending,
  output int                          sets_checked,
  output int                          overflow_sets
);

  logic [dwsv_pkg::YEAR_W-1:0] span_reg;
  logic [dwsv_pkg::YEAR_W-1:0] window_vals [dwsv_pkg::RING_DEPTH];
  int                          front_idx;
  int                          back_idx;
  int                          held;
  int                          peak_count;
  logic [dwsv_pkg::YEAR_W-1:0] peak_first;
  logic [dwsv_pkg::YEAR_W-1:0] peak_last;
  logic                        spilled;
  dwsv_pkg::out_item_t         pending_windows [$];
  int                          fails = 0;
  int                          checked = 0;
  int                          spill_sets = 0;

  task automatic clear_window();
    front_idx  = 0;
    back_idx   = 0;
    held       = 0;
    peak_count = 0;
    peak_first = '0;
    peak_last  = '0;
    spilled    = 1'b0;
  endtask

  task automatic absorb_year(input logic [dwsv_pkg::YEAR_W-1:0] y, input logic fin);
    int                  span;
    dwsv_pkg::out_item_t res;
    span = (span_reg == '0) ? 1 : int'(span_reg);
    while (held > 0 && int'(window_vals[front_idx]) + span <= int'(y)) begin
      front_idx = (front_idx + 1) % dwsv_pkg::RING_DEPTH;
      held--;
    end
    if (held >= dwsv_pkg::RING_DEPTH) begin
      front_idx = (front_idx + 1) % dwsv_pkg::RING_DEPTH;
      held--;
      spilled = 1'b1;
    end
    window_vals[back_idx] = y;
    back_idx = (back_idx + 1) % dwsv_pkg::RING_DEPTH;
    held++;
    if (held > peak_count) begin
      peak_count = held;
      peak_first = window_vals[front_idx];
      peak_last  = y;
    end
    if (fin) begin
      res.best_count = (peak_count > dwsv_pkg::COUNT_MAX) ?
                       dwsv_pkg::COUNT_W'(dwsv_pkg::COUNT_MAX) :
                       dwsv_pkg::COUNT_W'(peak_count);
      res.best_start = peak_first;
      res.best_end   = peak_last;
      res.overflow   = spilled;
      pending_windows.push_back(res);
      clear_window();
    end
  endtask

  always @(posedge clk) begin
    dwsv_pkg::out_item_t want;
    if (!rst_n) begin
      span_reg = 16'd1;
      clear_window();
      pending_windows.delete();
    end else begin
      if (cfg_we) begin
        span_reg = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        absorb_year(in_data.year, in_data.last);
      end
      if (out_valid && out_ready) begin
        if (pending_windows.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none,", $time);
          $display("%0t:   got count %0d start %0d end %0d overflow %0b",
                   $time, out_data.best_count, out_data.best_start, out_data.best_end,
                   out_data.overflow);
        end else begin
          want = pending_windows.pop_front();
          checked++;
          if (want.overflow) begin
            spill_sets++;
          end
          if (out_data !== want) begin
            fails++;
            $display("%0t: result mismatch, expected count %0d start %0d end %0d overflow %0b",
                     $time, want.best_count, want.best_start, want.best_end, want.overflow);
            $display("%0t:                  got      count %0d start %0d end %0d overflow %0b",
                     $time, out_data.best_count, out_data.best_start, out_data.best_end,
                     out_data.overflow);
          end
        end
      end
    end
    mismatches    <= fails;
    sets_pending  <= pending_windows.size();
    sets_checked  <= checked;
    overflow_sets <= spill_sets;
  end

endmodule

// ----- tb/sv/tb_densest_window_of_sorted_values.sv -----
`timescale 1ns / 100ps
module tb_densest_window_of_sorted_values;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 64;
  localparam int SEGMENT_ITEMS = 50;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  dwsv_pkg::in_item_t          in_data = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  dwsv_pkg::out_item_t         out_data;
  logic                        cfg_we = 1'b0;
  logic [dwsv_pkg::YEAR_W-1:0] cfg_wdata = '0;

  int mismatches;
  int sets_pending;
  int sets_checked;
  int overflow_sets;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycles = 0;
  int values_sent = 0;
  int windows_written = 0;
  int cur_window = 1;

  always #5 clk = ~clk;

  densest_window_of_sorted_values dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  densest_window_tracker tracker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .sets_pending  (sets_pending),
    .sets_checked  (sets_checked),
    .overflow_sets (overflow_sets)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_value(input logic [dwsv_pkg::YEAR_W-1:0] y, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{year: y, last: fin};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    values_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sets_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(input int w);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= dwsv_pkg::YEAR_W'(w);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_window = w;
    windows_written++;
  endtask

  task automatic run_sets(input int budget);
    int   sent;
    int   len;
    int   r;
    int   y;
    int   step;
    int   span;
    int   k;
    logic scramble;
    span = (cur_window == 0) ? 1 : cur_window;
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
      scramble = ($urandom_range(99) < 12);
      r = $urandom_range(9);
      y = (r == 0) ? 0 : (r == 1) ? 65535 - $urandom_range(200) : $urandom_range(65535);
      for (k = 0; k < len; k++) begin
        if (k > 0) begin
          if (scramble) begin
            y = $urandom_range(65535);
          end else begin
            r = $urandom_range(99);
            step = (r < 30) ? 0 :
                   (r < 80) ? $urandom_range(span) :
                   (r < 95) ? $urandom_range(2 * span) : $urandom_range(65535);
            y = (y + step > 65535) ? 65535 : y + step;
          end
        end
        send_value(dwsv_pkg::YEAR_W'(y), k == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    int p;
    int k;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The window is still at its reset span of one value here.
    send_value(16'd0, 1'b1);
    send_value(16'd65535, 1'b1);
    send_value(16'd5, 1'b0);
    send_value(16'd5, 1'b0);
    send_value(16'd5, 1'b0);
    send_value(16'd6, 1'b0);
    send_value(16'd6, 1'b1);

    // A zero span behaves like a span of one.
    set_window(0);
    send_value(16'd7, 1'b0);
    send_value(16'd7, 1'b0);
    send_value(16'd8, 1'b0);
    send_value(16'd8, 1'b0);
    send_value(16'd8, 1'b1);

    set_window(65535);
    send_value(16'd0, 1'b0);
    send_value(16'd65535, 1'b1);

    // Two windows reach the same count; the earlier one must be reported.
    set_window(3);
    send_value(16'd1, 1'b0);
    send_value(16'd2, 1'b0);
    send_value(16'd10, 1'b0);
    send_value(16'd11, 1'b1);

    // Values out of order are taken as they come.
    set_window(5);
    send_value(16'd10, 1'b0);
    send_value(16'd3, 1'b0);
    send_value(16'd20, 1'b1);

    for (p = 0; p < 4; p++) begin
      drain_results();
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 71;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 71;
        end
        default: begin
          send_idle_pct  = 8;
          recv_stall_pct = 8;
        end
      endcase
      for (k = 0; k < 3; k++) begin
        case (p * 3 + k)
          0:       set_window(1);
          1:       set_window(0);
          2:       set_window($urandom_range(65535));
          3:       set_window(65535);
          4:       set_window(3);
          5:       set_window($urandom_range(2, 40));
          6:       set_window(2);
          7:       set_window(500);
          8:       set_window($urandom_range(65535));
          9:       set_window(12);
          10:      set_window(1);
          default: set_window($urandom_range(41, 4000));
        endcase
        run_sets(SEGMENT_ITEMS);
      end
    end

    // One set longer than the ring, all inside one wide window, then a short set after it.
    set_window(65535);
    for (k = 0; k < 1030; k++) begin
      send_value(dwsv_pkg::YEAR_W'(100 + k / 4), k == 1029);
    end
    send_value(16'd40000, 1'b0);
    send_value(16'd40001, 1'b1);

    drain_results();
    $display("Run covered %0d values in %0d sets over %0d window settings and four idle patterns.",
             values_sent, sets_checked, windows_written);
    $display("Sets that overflowed the ring: %0d; mismatches: %0d.", overflow_sets, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/dwsv_pkg.sv
rtl/dwsv_ram.sv
rtl/dwsv_front.sv
rtl/dwsv_back.sv
rtl/densest_window_of_sorted_values.sv
tb/sv/densest_window_tracker.sv
tb/sv/tb_densest_window_of_sorted_values.sv
